@@ hdl/pita_pkg.sv @@
// ----------------------------------------------------------------------------
// pita_pkg : shared definitions for the pending request age tracker
// Field widths, default sizes, operation and register codes, sequencer
// states and the modes of the shared step unit.
// ----------------------------------------------------------------------------
package pita_pkg;

    // default sizes handed to the top level parameters
    localparam int NUM_TYPES_DEF  = 8;
    localparam int RING_SLOTS_DEF = 64;
    localparam int COUNT_BITS_DEF = 16;

    // fixed field widths of the request and result items
    localparam int OP_W      = 3;
    localparam int TYPE_IN_W = 3;
    localparam int SLOT_IN_W = 6;
    localparam int OUT_PTR_W = 6;
    localparam int THR_W     = 7;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 7;
    localparam int S_DATA_W  = 16;
    localparam int M_DATA_W  = 24;

    localparam logic [THR_W-1:0] THR_RESET = 7'd32;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'd1;

    // request operation codes
    typedef enum logic [OP_W-1:0] {
        OP_ISSUE    = 3'd0,
        OP_COMPLETE = 3'd1,
        OP_SETCUR   = 3'd2,
        OP_ADVANCE  = 3'd3,
        OP_CHECK    = 3'd4
    } op_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_UPDATE,
        ST_SETCUR,
        ST_SCAN,
        ST_FINISH
    } state_t;

    // shared step unit modes
    typedef enum logic [1:0] {
        UNIT_CNT_INC,
        UNIT_CNT_DEC,
        UNIT_PTR_INC,
        UNIT_PTR_SUB
    } unit_mode_t;

endpackage

@@ hdl/pita_bucket_mem.sv @@
// ----------------------------------------------------------------------------
// pita_bucket_mem : bucket count storage
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pita_bucket_mem #(
    parameter int DEPTH  = 512,
    parameter int AW     = 9,
    parameter int DATA_W = 16
) (
    input  logic              clk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [AW-1:0]     raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    // write the addressed bucket
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // register the read data
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

@@ hdl/pita_step_unit.sv @@
// ----------------------------------------------------------------------------
// pita_step_unit : shared adder for counts and ring pointers
// Saturating count increment and decrement, pointer increment with wrap,
// and pointer difference modulo the ring size, all on one adder.
// ----------------------------------------------------------------------------
module pita_step_unit #(
    parameter int COUNT_BITS = 16,
    parameter int RING_SLOTS = 64,
    parameter int PTR_W      = 6
) (
    input  pita_pkg::unit_mode_t   mode,
    input  logic [COUNT_BITS-1:0]  cnt_in,
    input  logic [PTR_W-1:0]       ptr_a,
    input  logic [PTR_W-1:0]       ptr_b,
    output logic [COUNT_BITS-1:0]  cnt_out,
    output logic                   cnt_neg,
    output logic [PTR_W-1:0]       ptr_out
);

    localparam int UW = (COUNT_BITS > PTR_W + 1) ? COUNT_BITS : PTR_W + 1;

    localparam logic [COUNT_BITS-1:0] CNT_MAX = {1'b0, {(COUNT_BITS-1){1'b1}}};
    localparam logic [COUNT_BITS-1:0] CNT_MIN = {1'b1, {(COUNT_BITS-1){1'b0}}};

    logic [UW-1:0] op_a;
    logic [UW-1:0] op_b;
    logic          carry_in;
    logic [UW-1:0] sum;
    logic [UW-1:0] sum_wrap;
    logic          saturate;

    // select operands for the adder
    always_comb
    begin
        op_a     = UW'(ptr_a);
        op_b     = UW'(1);
        carry_in = 1'b0;
        saturate = 1'b0;
        unique case (mode)
            pita_pkg::UNIT_CNT_INC:
            begin
                op_a     = UW'($signed(cnt_in));
                saturate = (cnt_in == CNT_MAX);
            end
            pita_pkg::UNIT_CNT_DEC:
            begin
                op_a     = UW'($signed(cnt_in));
                op_b     = '1;
                saturate = (cnt_in == CNT_MIN);
            end
            pita_pkg::UNIT_PTR_INC:
            begin
                op_b = UW'(1);
            end
            pita_pkg::UNIT_PTR_SUB:
            begin
                op_b     = ~UW'(ptr_b);
                carry_in = 1'b1;
            end
            default:
            begin
                op_b = UW'(1);
            end
        endcase
    end

    assign sum      = op_a + op_b + UW'(carry_in);
    assign sum_wrap = sum + UW'(RING_SLOTS);

    // hold the count at its limits
    assign cnt_out = saturate ? cnt_in : sum[COUNT_BITS-1:0];
    assign cnt_neg = cnt_out[COUNT_BITS-1];

    // wrap the pointer around the ring
    always_comb
    begin
        ptr_out = sum[PTR_W-1:0];
        if (mode == pita_pkg::UNIT_PTR_INC && sum == UW'(RING_SLOTS))
        begin
            ptr_out = '0;
        end
        else if (mode == pita_pkg::UNIT_PTR_SUB && sum[UW-1])
        begin
            ptr_out = sum_wrap[PTR_W-1:0];
        end
    end

endmodule

@@ hdl/pending_io_age_tracker.sv @@
// ----------------------------------------------------------------------------
// pending_io_age_tracker : per-type ring of pending request counts
// Tracks outstanding requests per callback type in time-slot buckets, with
// an oldest-slot pointer per type and one shared current-slot pointer.
//
//   channel | direction | handshake          | contents
//   --------+-----------+--------------------+--------------------------------
//   s_      | in        | s_tvalid/s_tready  | tuser: operation; tdata: type,
//           |           |                    |   slot
//   m_      | out       | m_tvalid/m_tready  | tdata: result flags, pointers
//   cfg_    | in        | cfg_wr_en          | enable, timeout threshold
//
// Paths: issue and complete pass read, update and finish; set current passes
// setcur and finish; check and ignored requests go straight to finish; advance
// oldest scans the buckets, then finishes, as the single bucket read port and
// shared step adder require. After reset a clearing pass writes zero to every
// bucket, one a cycle, NUM_TYPES * 2**clog2(RING_SLOTS) buckets (512 by default);
// no request is taken meanwhile, configuration writes are. A result waiting on
// m_tready does not block the next request; only its final load waits.
// ----------------------------------------------------------------------------
module pending_io_age_tracker #(
    parameter int NUM_TYPES  = pita_pkg::NUM_TYPES_DEF,
    parameter int RING_SLOTS = pita_pkg::RING_SLOTS_DEF,
    parameter int COUNT_BITS = pita_pkg::COUNT_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration write port
    input  logic                            cfg_wr_en,
    input  logic [pita_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [pita_pkg::CFG_DAT_W-1:0]  cfg_wdata,
    // request channel
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // s_tdata: callback_type[2:0], time_slot[8:3], zero[15:9]
    input  logic [pita_pkg::S_DATA_W-1:0]   s_tdata,
    // s_tuser: operation[2:0]
    input  logic [pita_pkg::OP_W-1:0]       s_tuser,
    // result channel
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // m_tdata: timed_out[0], pending_age[6:1], oldest_slot[12:7],
    //          current_position[18:13], count_underflow[19],
    //          slot_collision[20], zero[23:21]
    output logic [pita_pkg::M_DATA_W-1:0]   m_tdata
);

    localparam int PTR_W  = $clog2(RING_SLOTS);
    localparam int TYPE_W = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
    localparam int DEPTH  = NUM_TYPES * (2 ** PTR_W);
    localparam int AW     = $clog2(DEPTH);
    localparam int OW     = (PTR_W > pita_pkg::OUT_PTR_W) ? PTR_W : pita_pkg::OUT_PTR_W;
    localparam int CW     = (PTR_W > pita_pkg::THR_W) ? PTR_W : pita_pkg::THR_W;
    localparam int SLOT_N = 2 ** pita_pkg::SLOT_IN_W;

    pita_pkg::state_t state_reg, state_next;

    logic [pita_pkg::OP_W-1:0]  op_reg;
    logic [TYPE_W-1:0]          typ_reg;
    logic [PTR_W-1:0]           slot_reg;
    logic                       tok_reg;
    logic [PTR_W-1:0]           cur_reg;
    logic [PTR_W-1:0]           oldest_reg [NUM_TYPES];
    logic [PTR_W-1:0]           pos_reg;
    logic [PTR_W-1:0]           rd_pos_reg;
    logic                       rd_vld_reg;
    logic                       under_reg;
    logic                       coll_reg;
    logic [AW-1:0]              clr_reg;
    logic                       en_reg;
    logic [pita_pkg::THR_W-1:0] thr_reg;
    logic                       m_tvalid_reg;
    logic [pita_pkg::M_DATA_W-1:0] m_tdata_reg;

    logic [pita_pkg::TYPE_IN_W-1:0] in_type;
    logic [pita_pkg::SLOT_IN_W-1:0] in_slot;
    logic [PTR_W-1:0]               slot_table [SLOT_N];
    logic                           in_type_ok;
    logic                           accept;
    logic                           out_free;

    logic                     mem_we;
    logic [AW-1:0]            mem_waddr;
    logic [COUNT_BITS-1:0]    mem_wdata;
    logic [AW-1:0]            mem_raddr;
    logic [COUNT_BITS-1:0]    mem_rdata;

    pita_pkg::unit_mode_t     unit_mode;
    logic [PTR_W-1:0]         unit_ptr_a;
    logic [PTR_W-1:0]         old_sel;
    logic [COUNT_BITS-1:0]    unit_cnt;
    logic                     unit_neg;
    logic [PTR_W-1:0]         unit_ptr;

    logic                     scan_hit;
    logic                     scan_stop;
    logic [PTR_W-1:0]         scan_pos;
    logic                     coll_any;
    logic [OW-1:0]            age_w;
    logic [OW-1:0]            old_w;
    logic [OW-1:0]            cur_w;
    logic                     timed;

    // split the request fields
    assign in_type    = s_tdata[2:0];
    assign in_slot    = s_tdata[8:3];
    assign in_type_ok = (32'(in_type) < NUM_TYPES);
    assign accept     = s_tvalid && s_tready;
    assign out_free   = !m_tvalid_reg || m_tready;

    // reduce the slot field into the ring
    for (genvar g = 0; g < SLOT_N; g++)
    begin : g_slot_table
        assign slot_table[g] = PTR_W'(g % RING_SLOTS);
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_reg  <= 1'b0;
            thr_reg <= pita_pkg::THR_RESET;
        end
        else if (cfg_wr_en)
        begin
            if (cfg_addr == pita_pkg::CFG_ENABLE)
            begin
                en_reg <= cfg_wdata[0];
            end
            if (cfg_addr == pita_pkg::CFG_THRESHOLD)
            begin
                thr_reg <= cfg_wdata;
            end
        end
    end

    // oldest pointer of the addressed type
    assign old_sel = tok_reg ? oldest_reg[typ_reg] : '0;

    // compare the new current slot with every oldest pointer
    always_comb
    begin
        coll_any = 1'b0;
        for (int i = 0; i < NUM_TYPES; i++)
        begin
            coll_any = coll_any | (oldest_reg[i] == slot_reg);
        end
    end

    pita_bucket_mem #(
        .DEPTH  (DEPTH),
        .AW     (AW),
        .DATA_W (COUNT_BITS)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    pita_step_unit #(
        .COUNT_BITS (COUNT_BITS),
        .RING_SLOTS (RING_SLOTS),
        .PTR_W      (PTR_W)
    ) u_unit (
        .mode    (unit_mode),
        .cnt_in  (mem_rdata),
        .ptr_a   (unit_ptr_a),
        .ptr_b   (old_sel),
        .cnt_out (unit_cnt),
        .cnt_neg (unit_neg),
        .ptr_out (unit_ptr)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pita_pkg::ST_CLEAR:
            begin
                if (clr_reg == AW'(DEPTH - 1))
                begin
                    state_next = pita_pkg::ST_IDLE;
                end
            end
            pita_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = pita_pkg::ST_FINISH;
                    if (en_reg)
                    begin
                        unique case (s_tuser)
                            pita_pkg::OP_ISSUE, pita_pkg::OP_COMPLETE:
                            begin
                                if (in_type_ok)
                                begin
                                    state_next = pita_pkg::ST_READ;
                                end
                            end
                            pita_pkg::OP_SETCUR:
                            begin
                                state_next = pita_pkg::ST_SETCUR;
                            end
                            pita_pkg::OP_ADVANCE:
                            begin
                                if (in_type_ok)
                                begin
                                    state_next = pita_pkg::ST_SCAN;
                                end
                            end
                            default:
                            begin
                                state_next = pita_pkg::ST_FINISH;
                            end
                        endcase
                    end
                end
            end
            pita_pkg::ST_READ:   state_next = pita_pkg::ST_UPDATE;
            pita_pkg::ST_UPDATE: state_next = pita_pkg::ST_FINISH;
            pita_pkg::ST_SETCUR: state_next = pita_pkg::ST_FINISH;
            pita_pkg::ST_SCAN:
            begin
                if (scan_stop)
                begin
                    state_next = pita_pkg::ST_FINISH;
                end
            end
            pita_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = pita_pkg::ST_IDLE;
                end
            end
            default: state_next = pita_pkg::ST_IDLE;
        endcase
    end

    // outputs of the sequencer: memory port, unit mode, scan decision
    always_comb
    begin
        s_tready   = (state_reg == pita_pkg::ST_IDLE);
        mem_we     = 1'b0;
        mem_waddr  = AW'({typ_reg, slot_reg});
        mem_wdata  = unit_cnt;
        mem_raddr  = AW'({typ_reg, slot_reg});
        unit_mode  = pita_pkg::UNIT_PTR_SUB;
        unit_ptr_a = cur_reg;
        scan_hit   = rd_vld_reg && (mem_rdata != '0);
        scan_stop  = 1'b0;
        scan_pos   = pos_reg;
        unique case (state_reg)
            pita_pkg::ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
            end
            pita_pkg::ST_UPDATE:
            begin
                mem_we    = 1'b1;
                unit_mode = (op_reg == pita_pkg::OP_COMPLETE) ?
                            pita_pkg::UNIT_CNT_DEC : pita_pkg::UNIT_CNT_INC;
            end
            pita_pkg::ST_SCAN:
            begin
                mem_raddr  = AW'({typ_reg, pos_reg});
                unit_mode  = pita_pkg::UNIT_PTR_INC;
                unit_ptr_a = pos_reg;
                if (scan_hit)
                begin
                    scan_stop = 1'b1;
                    scan_pos  = rd_pos_reg;
                end
                else if (pos_reg == cur_reg)
                begin
                    scan_stop = 1'b1;
                end
            end
            default:
            begin
                unit_mode = pita_pkg::UNIT_PTR_SUB;
            end
        endcase
    end

    // state and clear counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pita_pkg::ST_CLEAR;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == pita_pkg::ST_CLEAR)
            begin
                clr_reg <= clr_reg + AW'(1);
            end
        end
    end

    // pointers, scan tracking and flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg    <= '0;
            rd_vld_reg <= 1'b0;
            for (int i = 0; i < NUM_TYPES; i++)
            begin
                oldest_reg[i] <= '0;
            end
        end
        else
        begin
            unique case (state_reg)
                pita_pkg::ST_IDLE:
                begin
                    rd_vld_reg <= 1'b0;
                end
                pita_pkg::ST_SETCUR:
                begin
                    cur_reg <= slot_reg;
                end
                pita_pkg::ST_SCAN:
                begin
                    if (scan_stop)
                    begin
                        oldest_reg[typ_reg] <= scan_pos;
                        rd_vld_reg          <= 1'b0;
                    end
                    else
                    begin
                        rd_vld_reg <= 1'b1;
                    end
                end
                default:
                begin
                    rd_vld_reg <= rd_vld_reg;
                end
            endcase
        end
    end

    // request capture and per-request payload
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            pita_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    op_reg    <= s_tuser;
                    typ_reg   <= TYPE_W'(in_type);
                    slot_reg  <= slot_table[in_slot];
                    tok_reg   <= in_type_ok;
                    under_reg <= 1'b0;
                    coll_reg  <= 1'b0;
                    pos_reg   <= in_type_ok ? oldest_reg[TYPE_W'(in_type)] : '0;
                end
            end
            pita_pkg::ST_UPDATE:
            begin
                under_reg <= (op_reg == pita_pkg::OP_COMPLETE) && unit_neg;
            end
            pita_pkg::ST_SETCUR:
            begin
                coll_reg <= coll_any;
            end
            pita_pkg::ST_SCAN:
            begin
                if (!scan_stop)
                begin
                    rd_pos_reg <= pos_reg;
                    pos_reg    <= unit_ptr;
                end
            end
            default:
            begin
                pos_reg <= pos_reg;
            end
        endcase
    end

    // assemble the result
    assign age_w = tok_reg ? OW'(unit_ptr) : '0;
    assign old_w = OW'(old_sel);
    assign cur_w = OW'(cur_reg);
    assign timed = en_reg && tok_reg && (op_reg == pita_pkg::OP_CHECK) &&
                   (CW'(thr_reg) <= CW'(unit_ptr));

    // hold the result until the master side takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (state_reg == pita_pkg::ST_FINISH && out_free)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == pita_pkg::ST_FINISH && out_free)
        begin
            m_tdata_reg <= {3'b000, coll_reg, under_reg,
                            cur_w[pita_pkg::OUT_PTR_W-1:0],
                            old_w[pita_pkg::OUT_PTR_W-1:0],
                            age_w[pita_pkg::OUT_PTR_W-1:0], timed};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // one request at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
    else $error("request accepted while another is in flight");

    // results appear only from the finish step
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> ($past(state_reg) == pita_pkg::ST_FINISH))
    else $error("result raised outside the finish step");

    // underflow and collision come from different operations
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[19] && m_tdata[20]))
    else $error("underflow and collision flagged together");

    // buckets change only during clearing or a count update
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == pita_pkg::ST_CLEAR || state_reg == pita_pkg::ST_UPDATE))
    else $error("bucket written outside clear or update");

    // a scan ends in the finish step
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pita_pkg::ST_SCAN) |=>
        (state_reg == pita_pkg::ST_SCAN || state_reg == pita_pkg::ST_FINISH))
    else $error("scan left without finishing");

endmodule

@@ tb/sv/tb_pending_io_age_tracker.sv @@
// ----------------------------------------------------------------------------
// tb_pending_io_age_tracker : self-checking bench for the pending age tracker
// Drives request items on the s_ stream and checks every m_ result field
// against a local predictor of the bucket counts and slot pointers. A short
// table of directed requests opens the run. Random request streams follow,
// biased toward slots near the current pointer so that buckets drain and the
// oldest-pointer scan travels. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb_pending_io_age_tracker;

    localparam int NUM_T       = pita_pkg::NUM_TYPES_DEF;
    localparam int RING        = pita_pkg::RING_SLOTS_DEF;
    localparam int CBITS       = pita_pkg::COUNT_BITS_DEF;
    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int TAIL_CYCLES = RING + 16;

    localparam logic signed [CBITS-1:0] CNT_MAX = {1'b0, {(CBITS-1){1'b1}}};
    localparam logic signed [CBITS-1:0] CNT_MIN = {1'b1, {(CBITS-1){1'b0}}};

    // one result item, unpacked from m_tdata
    typedef struct packed {
        logic       timed_out;
        logic [5:0] pending_age;
        logic [5:0] oldest_slot;
        logic [5:0] current_position;
        logic       count_underflow;
        logic       slot_collision;
    } age_report_t;

    typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

    // one line of the directed table: a request or a register setting
    typedef struct {
        row_kind_t                  kind;
        pita_pkg::op_t              op;
        logic [2:0]                 ty;
        logic [5:0]                 sl;
        bit                         typed;
        age_report_t                want;
        bit                         en;
        logic [pita_pkg::THR_W-1:0] thr;
    } dir_row_t;

    logic                            clk;
    logic                            rst_n     = 1'b0;
    logic                            cfg_wr_en = 1'b0;
    logic [pita_pkg::CFG_IDX_W-1:0]  cfg_addr  = '0;
    logic [pita_pkg::CFG_DAT_W-1:0]  cfg_wdata = '0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [pita_pkg::S_DATA_W-1:0]   s_tdata   = '0;
    logic [pita_pkg::OP_W-1:0]       s_tuser   = '0;
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [pita_pkg::M_DATA_W-1:0]   m_tdata;

    // predictor state
    logic signed [CBITS-1:0]    bucket_cnt [NUM_T][RING];
    logic [5:0]                 oldest_ptr [NUM_T];
    logic [5:0]                 cur_slot;
    logic                       trk_enable;
    logic [pita_pkg::THR_W-1:0] trk_threshold;

    age_report_t expected_reports [$];
    dir_row_t    dir_rows [$];

    int send_idle_pct = 23;
    int recv_idle_pct = 47;
    int err_count     = 0;
    int n_requests    = 0;
    int n_checked     = 0;
    int cycle_count   = 0;

    pending_io_age_tracker DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // hard stop for a hung block
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_reports.size());
            $display("tb_pending_io_age_tracker: errors");
            $finish;
        end
    end

    function automatic age_report_t rep(bit to, int age, int old, int cur, bit un, bit co);
        age_report_t r;
        r.timed_out        = to;
        r.pending_age      = 6'(age);
        r.oldest_slot      = 6'(old);
        r.current_position = 6'(cur);
        r.count_underflow  = un;
        r.slot_collision   = co;
        return r;
    endfunction

    function automatic dir_row_t req_row(pita_pkg::op_t op, int ty, int sl,
                                         bit typed = 1'b0, age_report_t want = '0);
        dir_row_t r;
        r.kind  = ROW_REQ;
        r.op    = op;
        r.ty    = 3'(ty);
        r.sl    = 6'(sl);
        r.typed = typed;
        r.want  = want;
        r.en    = 1'b0;
        r.thr   = '0;
        return r;
    endfunction

    function automatic dir_row_t cfg_row(bit en, int thr);
        dir_row_t r;
        r      = req_row(pita_pkg::OP_CHECK, 0, 0);
        r.kind = ROW_CFG;
        r.en   = en;
        r.thr  = pita_pkg::THR_W'(thr);
        return r;
    endfunction

    // append one line to the directed table
    function automatic void add_row(dir_row_t r);
        dir_rows.insert(dir_rows.size(), r);
    endfunction

    // apply one request to the predictor state and return its report
    function automatic age_report_t predict_age_report(pita_pkg::op_t op, logic [2:0] ty,
                                                       logic [5:0] sl);
        age_report_t r;
        logic [5:0]  p;
        bit          type_ok;
        int          n;
        r       = '0;
        type_ok = int'(ty) < NUM_T;
        if (trk_enable)
        begin
            case (op)
                pita_pkg::OP_ISSUE:
                    if (type_ok && bucket_cnt[ty][sl] != CNT_MAX)
                        bucket_cnt[ty][sl] = bucket_cnt[ty][sl] + CBITS'(1);
                pita_pkg::OP_COMPLETE:
                    if (type_ok)
                    begin
                        if (bucket_cnt[ty][sl] != CNT_MIN)
                            bucket_cnt[ty][sl] = bucket_cnt[ty][sl] - CBITS'(1);
                        r.count_underflow = bucket_cnt[ty][sl] < 0;
                    end
                pita_pkg::OP_SETCUR:
                begin
                    cur_slot = sl;
                    for (n = 0; n < NUM_T; n++)
                        if (oldest_ptr[n] == cur_slot)
                            r.slot_collision = 1'b1;
                end
                pita_pkg::OP_ADVANCE:
                    if (type_ok)
                    begin
                        // skip empty buckets, never past the current slot
                        p = oldest_ptr[ty];
                        for (n = 0; n < RING && bucket_cnt[ty][p] == 0 && p != cur_slot; n++)
                            p = p + 6'd1;
                        oldest_ptr[ty] = p;
                    end
                default: ;
            endcase
        end
        r.current_position = cur_slot;
        if (type_ok)
        begin
            r.oldest_slot = oldest_ptr[ty];
            r.pending_age = cur_slot - oldest_ptr[ty];
            r.timed_out   = trk_enable && op == pita_pkg::OP_CHECK &&
                            int'(trk_threshold) <= int'(r.pending_age);
        end
        return r;
    endfunction

    function automatic void check_field(string name, logic [6:0] want, logic [6:0] got);
        if (got !== want)
        begin
            err_count++;
            $error("%s: expected %0d, got %0d", name, want, got);
        end
    endfunction

    // present one request, hold it until taken, then log its expected report
    task automatic send_req(pita_pkg::op_t op, logic [2:0] ty, logic [5:0] sl, bit typed,
                            age_report_t want);
        age_report_t r;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(pita_pkg::S_DATA_W-9){1'b0}}, sl, ty};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        r = predict_age_report(op, ty, sl);
        expected_reports.insert(expected_reports.size(), typed ? want : r);
        n_requests++;
    endtask

    task automatic drain_reports();
        s_tvalid <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge clk);
    endtask

    // write both registers once the block has gone quiet
    task automatic set_config(bit en, logic [pita_pkg::THR_W-1:0] thr);
        drain_reports();
        cfg_wr_en <= 1'b1;
        cfg_addr  <= pita_pkg::CFG_ENABLE;
        cfg_wdata <= pita_pkg::CFG_DAT_W'(en);
        @(posedge clk);
        trk_enable = en;
        cfg_addr   <= pita_pkg::CFG_THRESHOLD;
        cfg_wdata  <= pita_pkg::CFG_DAT_W'(thr);
        @(posedge clk);
        trk_threshold = thr;
        cfg_wr_en <= 1'b0;
    endtask

    // random requests, mostly near the current slot so buckets fill and drain
    task automatic run_random(int count);
        int            k;
        int            pick;
        int            n;
        pita_pkg::op_t op;
        logic [2:0]    ty;
        logic [5:0]    sl;
        for (k = 0; k < count; k++)
        begin
            pick = $urandom_range(99);
            ty   = 3'($urandom_range(NUM_T - 1));
            sl   = 6'($urandom_range(RING - 1));
            if (pick < 28)
            begin
                op = pita_pkg::OP_ISSUE;
                if ($urandom_range(9) != 0)
                    sl = cur_slot - 6'($urandom_range(7));
            end
            else if (pick < 50)
            begin
                op = pita_pkg::OP_COMPLETE;
                // mostly retire the oldest pending bucket of the type
                if ($urandom_range(9) < 7)
                begin
                    sl = oldest_ptr[ty];
                    for (n = 0; n < RING - 1 && bucket_cnt[ty][sl] <= 0; n++)
                        sl = sl + 6'd1;
                end
            end
            else if (pick < 65)
            begin
                op = pita_pkg::OP_SETCUR;
                if ($urandom_range(4) != 0)
                    sl = cur_slot + 6'($urandom_range(1, 3));
            end
            else if (pick < 82)
                op = pita_pkg::OP_ADVANCE;
            else
                op = pita_pkg::OP_CHECK;
            send_req(op, ty, sl, 1'b0, '0);
        end
    endtask

    // check each result against the oldest expected report
    always @(posedge clk)
    begin
        age_report_t got;
        age_report_t want;
        if (rst_n)
            m_tready <= $urandom_range(99) >= recv_idle_pct;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.timed_out        = m_tdata[0];
            got.pending_age      = m_tdata[6:1];
            got.oldest_slot      = m_tdata[12:7];
            got.current_position = m_tdata[18:13];
            got.count_underflow  = m_tdata[19];
            got.slot_collision   = m_tdata[20];
            if (expected_reports.size() == 0)
            begin
                err_count++;
                $error("result with no request outstanding: m_tdata %h", m_tdata);
            end
            else
            begin
                want = expected_reports.pop_front();
                check_field("timed_out", 7'(want.timed_out), 7'(got.timed_out));
                check_field("pending_age", 7'(want.pending_age), 7'(got.pending_age));
                check_field("oldest_slot", 7'(want.oldest_slot), 7'(got.oldest_slot));
                check_field("current_position", 7'(want.current_position),
                            7'(got.current_position));
                check_field("count_underflow", 7'(want.count_underflow),
                            7'(got.count_underflow));
                check_field("slot_collision", 7'(want.slot_collision),
                            7'(got.slot_collision));
                n_checked++;
            end
        end
    end

    initial
    begin
        int       i;
        int       j;
        int       seg;
        int       n_directed;
        dir_row_t row;
        bit       seg_en  [6];
        int       seg_thr [6];
        int       seg_len [6];

        seg_en  = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1};
        seg_thr = '{16, 1, 40, 64, 0, 0};
        seg_len = '{240, 240, 60, 240, 240, 240};

        // reset image of the tracker
        for (i = 0; i < NUM_T; i++)
        begin
            oldest_ptr[i] = '0;
            for (j = 0; j < RING; j++)
                bucket_cnt[i][j] = '0;
        end
        cur_slot      = '0;
        trk_enable    = 1'b0;
        trk_threshold = pita_pkg::THR_RESET;
        seg_thr[5]    = $urandom_range(64);

        // disabled after reset: nothing moves, check stays low
        add_row(req_row(pita_pkg::OP_ISSUE, 0, 5, 1'b1, rep(0, 0, 0, 0, 0, 0)));
        add_row(req_row(pita_pkg::OP_SETCUR, 0, 63, 1'b1, rep(0, 0, 0, 0, 0, 0)));
        add_row(req_row(pita_pkg::OP_CHECK, 7, 0, 1'b1, rep(0, 0, 0, 0, 0, 0)));
        // zero threshold: every check times out
        add_row(cfg_row(1'b1, 0));
        add_row(req_row(pita_pkg::OP_CHECK, 3, 0, 1'b1, rep(1, 0, 0, 0, 0, 0)));
        add_row(req_row(pita_pkg::OP_SETCUR, 0, 0, 1'b1, rep(0, 0, 0, 0, 0, 1)));
        add_row(req_row(pita_pkg::OP_SETCUR, 5, 63, 1'b1, rep(0, 63, 0, 63, 0, 0)));
        add_row(req_row(pita_pkg::OP_ISSUE, 7, 63, 1'b1, rep(0, 63, 0, 63, 0, 0)));
        add_row(req_row(pita_pkg::OP_COMPLETE, 0, 0, 1'b1, rep(0, 63, 0, 63, 1, 0)));
        // a negative bucket blocks the scan
        add_row(req_row(pita_pkg::OP_ADVANCE, 0, 0, 1'b1, rep(0, 63, 0, 63, 0, 0)));
        add_row(req_row(pita_pkg::OP_ISSUE, 0, 0));
        add_row(req_row(pita_pkg::OP_ISSUE, 1, 3));
        add_row(req_row(pita_pkg::OP_ADVANCE, 1, 0));
        add_row(req_row(pita_pkg::OP_ADVANCE, 2, 0));
        add_row(req_row(pita_pkg::OP_CHECK, 2, 0));
        add_row(req_row(pita_pkg::OP_SETCUR, 4, 3));
        add_row(req_row(pita_pkg::OP_COMPLETE, 1, 3));
        // scan starts on the current slot and stops at once
        add_row(req_row(pita_pkg::OP_ADVANCE, 1, 0));
        add_row(req_row(pita_pkg::OP_SETCUR, 0, 40));
        add_row(req_row(pita_pkg::OP_ADVANCE, 1, 0));
        add_row(req_row(pita_pkg::OP_ADVANCE, 7, 0));
        // top threshold: the widest age stays below it
        add_row(cfg_row(1'b1, 64));
        add_row(req_row(pita_pkg::OP_SETCUR, 2, 63));
        add_row(req_row(pita_pkg::OP_CHECK, 3, 0, 1'b1, rep(0, 63, 0, 63, 0, 0)));
        add_row(cfg_row(1'b1, 63));
        add_row(req_row(pita_pkg::OP_CHECK, 6, 0));
        add_row(req_row(pita_pkg::OP_COMPLETE, 4, 63));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // walk the directed table
        foreach (dir_rows[k])
        begin
            row = dir_rows[k];
            if (row.kind == ROW_CFG)
                set_config(row.en, row.thr);
            else
                send_req(row.op, row.ty, row.sl, row.typed, row.want);
        end
        n_directed = n_requests;

        // random segments, each under its own register setting; the idle mix changes every two segments
        for (seg = 0; seg < 6; seg++)
        begin
            send_idle_pct = seg < 2 ? 23 : (seg < 4 ? 47 : 0);
            recv_idle_pct = seg < 2 ? 47 : (seg < 4 ? 23 : 0);
            set_config(seg_en[seg], pita_pkg::THR_W'(seg_thr[seg]));
            run_random(seg_len[seg]);
        end

        drain_reports();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("sent %0d requests: %0d from the directed table, the rest random",
                 n_requests, n_directed);
        $display("under six register settings; %0d results checked, %0d mismatches",
                 n_checked, err_count);
        if (err_count == 0)
            $display("tb_pending_io_age_tracker: clean");
        else
            $display("tb_pending_io_age_tracker: errors");
        $finish;
    end

endmodule

@@ pending_io_age_tracker.f @@
hdl/pita_pkg.sv
hdl/pita_bucket_mem.sv
hdl/pita_step_unit.sv
hdl/pending_io_age_tracker.sv
tb/sv/tb_pending_io_age_tracker.sv
